// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL. Each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/rsst_pkg.sv
// ---------------------------------------------------------------------------
// rsst_pkg
// Shared constants and types for the range-sum segment tree.
// ---------------------------------------------------------------------------
package rsst_pkg;

  localparam int LEAVES_DEF = 1024;  // default leaf count (power of two)
  localparam int IDX_W      = 10;    // leaf / range index field width
  localparam int VAL_W      = 64;    // node and sum width

  localparam logic REQ_SET   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_UP,
    ST_QRY_WALK,
    ST_QRY_LAST
  } state_t;

endpackage

// File: hdl/range_sum_segment_tree.sv
// ---------------------------------------------------------------------------
// range_sum_segment_tree
// Point-update, range-sum segment tree over LEAVES leaves in one node RAM.
// ---------------------------------------------------------------------------
// Usage: after rst_n the block sweeps its node RAM to zero, with busy high.
// A request transfers on a clock edge with start high and busy low. A set
// (in_req_type = 0) writes the leaf in the transfer cycle and then rebuilds
// one ancestor per cycle up to the root; a set whose in_leaf_index is at or
// above LEAVES is dropped and busy stays low. A query (in_req_type = 1)
// walks both range ends inward one tree level per cycle, at most
// log2(LEAVES)+1 levels; a final walk step folds in the last level's reads
// and ST_QRY_LAST closes the sum. The pace is set by the node RAM, read at
// both ends once per level, and the single shared 64-bit adder.
// Range ends at or above LEAVES are clamped to LEAVES-1; an empty range
// (low above high) gives zero. The result shows on out_range_sum for exactly
// one cycle with out_valid high, in the cycle where busy drops again; the
// receiver cannot stall it. Sums wrap modulo 2^64.
// ---------------------------------------------------------------------------
module range_sum_segment_tree #(
  parameter int LEAVES = rsst_pkg::LEAVES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_req_type,
  input  logic [rsst_pkg::IDX_W-1:0]       in_leaf_index,
  input  logic signed [rsst_pkg::VAL_W-1:0] in_leaf_value,
  input  logic [rsst_pkg::IDX_W-1:0]       in_range_low,
  input  logic [rsst_pkg::IDX_W-1:0]       in_range_high,
  output logic                             out_valid,
  output logic signed [rsst_pkg::VAL_W-1:0] out_range_sum
);
  import rsst_pkg::*;

  `include "assert_macros.svh"

  // Node addresses span 0 .. 2*LEAVES-1; walk pointers get one extra bit
  // since the low end's step sum can reach 2*LEAVES.
  localparam int NODES  = 2 * LEAVES;
  localparam int NODE_W = $clog2(NODES);
  localparam int PTR_W  = NODE_W + 1;
  localparam int EXT_W  = ((IDX_W > NODE_W) ? IDX_W : NODE_W) + 1;

  localparam logic [EXT_W-1:0]  LEAVES_E  = EXT_W'(LEAVES);
  localparam logic [NODE_W-1:0] NODE_LAST = '1;
  localparam logic [NODE_W-1:0] NODE_ROOT = NODE_W'(1);
  localparam logic [NODE_W-1:0] NODE_ONE  = NODE_W'(1);
  localparam logic [PTR_W-1:0]  NODES_P   = PTR_W'(NODES);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [NODE_W-1:0]   clr_r, clr_nxt;        // clearing sweep address
  logic [NODE_W-1:0]   k_r, k_nxt;            // set: node just written
  logic [VAL_W-1:0]    cur_r, cur_nxt;        // set: value at node k_r
  logic [PTR_W-1:0]    l_r, l_nxt;            // query: low walk pointer
  logic [PTR_W-1:0]    r_r, r_nxt;            // query: high walk pointer
  logic                take_l_r, take_l_nxt;  // add node l from last read
  logic                take_r_r, take_r_nxt;  // add node r from last read
  logic [VAL_W-1:0]    acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]    out_sum_r, out_sum_nxt;

  // Node RAM ports
  logic                ram_we;
  logic [NODE_W-1:0]   ram_waddr;
  logic [VAL_W-1:0]    ram_wdata;
  logic [NODE_W-1:0]   ram_ra, ram_rb;
  logic [VAL_W-1:0]    ram_rd_a, ram_rd_b;

  // Shared three-input adder
  logic [VAL_W-1:0]    add_a, add_b, add_c, add_sum;

  // Request decode
  logic [EXT_W-1:0]    idx_ext, lo_ext, hi_ext, lo_sat, hi_sat;
  logic [EXT_W-1:0]    leaf_sum, l_init, r_init;
  logic                idx_ok;
  logic [NODE_W-1:0]   leaf_node, parent;
  logic                walk_go;
  logic [PTR_W-1:0]    l_step, r_step;

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

  assign add_sum = add_a + add_b + add_c;

  // ---------------------------------------------------------------------
  // Request decode: leaf node for a set, clamped range ends for a query
  // ---------------------------------------------------------------------
  assign idx_ext   = EXT_W'(in_leaf_index);
  assign idx_ok    = (idx_ext < LEAVES_E);
  assign leaf_sum  = LEAVES_E + idx_ext;
  assign leaf_node = leaf_sum[NODE_W-1:0];

  assign lo_ext = EXT_W'(in_range_low);
  assign hi_ext = EXT_W'(in_range_high);
  assign lo_sat = (lo_ext >= LEAVES_E) ? (LEAVES_E - EXT_W'(1)) : lo_ext;
  assign hi_sat = (hi_ext >= LEAVES_E) ? (LEAVES_E - EXT_W'(1)) : hi_ext;
  assign l_init = LEAVES_E + lo_sat;
  assign r_init = LEAVES_E + hi_sat;

  // Set climb: parent of the node just written
  assign parent = k_r >> 1;

  // Query walk: an odd low end is a right child, taken and stepped past;
  // an even high end is a left child, taken and stepped before.
  assign walk_go = (l_r <= r_r) && (r_r != '0);
  assign l_step  = (l_r + PTR_W'(l_r[0])) >> 1;
  assign r_step  = (r_r - PTR_W'(!r_r[0])) >> 1;

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == NODE_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_req_type == REQ_QUERY) begin
            state_nxt = ST_QRY_WALK;
          end else if (idx_ok) begin
            state_nxt = ST_SET_UP;
          end
        end
      end
      ST_SET_UP: begin
        if (parent == NODE_ROOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QRY_WALK: begin
        if (!walk_go) begin
          state_nxt = ST_QRY_LAST;
        end
      end
      ST_QRY_LAST: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // RAM control, adder operands and datapath next values
  // ---------------------------------------------------------------------
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = '0;
    ram_ra        = k_r ^ NODE_ONE;
    ram_rb        = k_r;
    add_a         = '0;
    add_b         = '0;
    add_c         = '0;
    clr_nxt       = clr_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    take_l_nxt    = take_l_r;
    take_r_nxt    = take_r_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + NODE_ONE;
      end
      ST_IDLE: begin
        if (start && (in_req_type == REQ_SET) && idx_ok) begin
          // write the leaf and fetch its sibling for the first climb step
          ram_we    = 1'b1;
          ram_waddr = leaf_node;
          ram_wdata = in_leaf_value;
          ram_ra    = leaf_node ^ NODE_ONE;
          cur_nxt   = in_leaf_value;
          k_nxt     = leaf_node;
        end
        if (start && (in_req_type == REQ_QUERY)) begin
          l_nxt      = l_init[PTR_W-1:0];
          r_nxt      = r_init[PTR_W-1:0];
          take_l_nxt = 1'b0;
          take_r_nxt = 1'b0;
          acc_nxt    = '0;
        end
      end
      ST_SET_UP: begin
        // parent = this node + sibling; fetch the parent's sibling
        add_a     = cur_r;
        add_b     = ram_rd_a;
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = add_sum;
        ram_ra    = parent ^ NODE_ONE;
        cur_nxt   = add_sum;
        k_nxt     = parent;
      end
      ST_QRY_WALK: begin
        // fold in the nodes read last cycle, issue this level's reads
        add_a   = acc_r;
        add_b   = take_l_r ? ram_rd_a : '0;
        add_c   = take_r_r ? ram_rd_b : '0;
        acc_nxt = add_sum;
        ram_ra  = l_r[NODE_W-1:0];
        ram_rb  = r_r[NODE_W-1:0];
        if (walk_go) begin
          take_l_nxt = l_r[0];
          take_r_nxt = !r_r[0];
          l_nxt      = l_step;
          r_nxt      = r_step;
        end else begin
          take_l_nxt = 1'b0;
          take_r_nxt = 1'b0;
        end
      end
      ST_QRY_LAST: begin
        add_a         = acc_r;
        add_b         = take_l_r ? ram_rd_a : '0;
        add_c         = take_r_r ? ram_rd_b : '0;
        out_valid_nxt = 1'b1;
        out_sum_nxt   = add_sum;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    cur_r     <= cur_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    take_l_r  <= take_l_nxt;
    take_r_r  <= take_r_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
  end

  // ---------------------------------------------------------------------
  // Node RAM
  // ---------------------------------------------------------------------
  rsst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NODES)
  ) u_nodes (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_ra),
    .rdata_a (ram_rd_a),
    .raddr_b (ram_rb),
    .rdata_b (ram_rd_b)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_NEXT(a_result_after_last, state_r == ST_QRY_LAST, out_valid_r)
  `ASSERT_IMPL(a_no_write_in_query, (state_r == ST_QRY_WALK) || (state_r == ST_QRY_LAST), !ram_we)
  `ASSERT_IMPL(a_climb_below_root, state_r == ST_SET_UP, k_r > NODE_ROOT)
  `ASSERT_IMPL(a_walk_in_tree, state_r == ST_QRY_WALK, r_r < NODES_P)

endmodule

// File: hdl/rsst_ram.sv
// ---------------------------------------------------------------------------
// rsst_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module rsst_ram #(
  parameter int WIDTH = rsst_pkg::VAL_W,
  parameter int DEPTH = 2 * rsst_pkg::LEAVES_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);
  import rsst_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
